[src/hke_pkg.sv]
// Shared constants, orientation tables and pipeline types for the Hilbert key encoder.
// Used by the channel interfaces, the walk stage and the top level; depends on nothing.
package hke_pkg;

  localparam int COORD_W    = 32;
  localparam int KEY_W      = 57;
  localparam int MODE_W     = 2;
  localparam int LEVELS_2D  = 28;
  localparam int LEVELS_3D  = 19;
  localparam int NUM_STAGES = 4;

  // Levels handled by each walk stage. The last stage may walk a few extra
  // levels; their digits are dropped when the key is formatted.
  localparam int STEP_2D = (LEVELS_2D + NUM_STAGES - 1) / NUM_STAGES;
  localparam int STEP_3D = (LEVELS_3D + NUM_STAGES - 1) / NUM_STAGES;
  localparam int PAD_2D  = NUM_STAGES * STEP_2D - LEVELS_2D;
  localparam int PAD_3D  = NUM_STAGES * STEP_3D - LEVELS_3D;

  localparam int ACC_W_2D = 2 * NUM_STAGES * STEP_2D;
  localparam int ACC_W_3D = 3 * NUM_STAGES * STEP_3D;
  localparam int ACC_W    = (ACC_W_2D > ACC_W_3D) ? ACC_W_2D : ACC_W_3D;
  localparam int EXT_W    = (ACC_W > KEY_W) ? ACC_W : KEY_W;

  localparam int ST_W      = 5;
  localparam int ST3_COUNT = 24;

  localparam logic [MODE_W-1:0] MODE_2D    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd3;

  localparam logic [1:0] DIGIT2 [16] = '{
    2'd0, 2'd3, 2'd1, 2'd2,  2'd0, 2'd1, 2'd3, 2'd2,
    2'd2, 2'd3, 2'd1, 2'd0,  2'd2, 2'd1, 2'd3, 2'd0};

  localparam logic [1:0] NEXT2 [16] = '{
    2'd1, 2'd2, 2'd0, 2'd0,  2'd0, 2'd1, 2'd3, 2'd1,
    2'd2, 2'd0, 2'd2, 2'd3,  2'd3, 2'd3, 2'd1, 2'd2};

  localparam logic [2:0] DIGIT3 [192] = '{
    3'd0, 3'd7, 3'd3, 3'd4, 3'd1, 3'd6, 3'd2, 3'd5,
    3'd0, 3'd1, 3'd3, 3'd2, 3'd7, 3'd6, 3'd4, 3'd5,
    3'd0, 3'd3, 3'd7, 3'd4, 3'd1, 3'd2, 3'd6, 3'd5,
    3'd2, 3'd3, 3'd5, 3'd4, 3'd1, 3'd0, 3'd6, 3'd7,
    3'd4, 3'd5, 3'd3, 3'd2, 3'd7, 3'd6, 3'd0, 3'd1,
    3'd4, 3'd7, 3'd3, 3'd0, 3'd5, 3'd6, 3'd2, 3'd1,
    3'd6, 3'd7, 3'd5, 3'd4, 3'd1, 3'd0, 3'd2, 3'd3,
    3'd0, 3'd1, 3'd7, 3'd6, 3'd3, 3'd2, 3'd4, 3'd5,
    3'd2, 3'd1, 3'd5, 3'd6, 3'd3, 3'd0, 3'd4, 3'd7,
    3'd6, 3'd1, 3'd5, 3'd2, 3'd7, 3'd0, 3'd4, 3'd3,
    3'd0, 3'd7, 3'd1, 3'd6, 3'd3, 3'd4, 3'd2, 3'd5,
    3'd2, 3'd1, 3'd3, 3'd0, 3'd5, 3'd6, 3'd4, 3'd7,
    3'd4, 3'd7, 3'd5, 3'd6, 3'd3, 3'd0, 3'd2, 3'd1,
    3'd4, 3'd5, 3'd7, 3'd6, 3'd3, 3'd2, 3'd0, 3'd1,
    3'd6, 3'd1, 3'd7, 3'd0, 3'd5, 3'd2, 3'd4, 3'd3,
    3'd0, 3'd3, 3'd1, 3'd2, 3'd7, 3'd4, 3'd6, 3'd5,
    3'd2, 3'd3, 3'd1, 3'd0, 3'd5, 3'd4, 3'd6, 3'd7,
    3'd6, 3'd7, 3'd1, 3'd0, 3'd5, 3'd4, 3'd2, 3'd3,
    3'd2, 3'd5, 3'd1, 3'd6, 3'd3, 3'd4, 3'd0, 3'd7,
    3'd4, 3'd3, 3'd7, 3'd0, 3'd5, 3'd2, 3'd6, 3'd1,
    3'd4, 3'd3, 3'd5, 3'd2, 3'd7, 3'd0, 3'd6, 3'd1,
    3'd6, 3'd5, 3'd1, 3'd2, 3'd7, 3'd4, 3'd0, 3'd3,
    3'd2, 3'd5, 3'd3, 3'd4, 3'd1, 3'd6, 3'd0, 3'd7,
    3'd6, 3'd5, 3'd7, 3'd4, 3'd1, 3'd2, 3'd0, 3'd3};

  localparam logic [4:0] NEXT3 [192] = '{
    5'd1,  5'd6,  5'd3,  5'd4,  5'd2,  5'd5,  5'd0,  5'd0,
    5'd0,  5'd7,  5'd8,  5'd1,  5'd9,  5'd4,  5'd5,  5'd1,
    5'd15, 5'd22, 5'd23, 5'd20, 5'd0,  5'd2,  5'd19, 5'd2,
    5'd3,  5'd23, 5'd3,  5'd15, 5'd6,  5'd20, 5'd16, 5'd22,
    5'd11, 5'd4,  5'd12, 5'd4,  5'd20, 5'd1,  5'd22, 5'd13,
    5'd22, 5'd12, 5'd20, 5'd11, 5'd5,  5'd0,  5'd5,  5'd19,
    5'd17, 5'd0,  5'd6,  5'd21, 5'd3,  5'd9,  5'd6,  5'd2,
    5'd10, 5'd1,  5'd14, 5'd13, 5'd11, 5'd7,  5'd12, 5'd7,
    5'd8,  5'd9,  5'd8,  5'd18, 5'd14, 5'd12, 5'd10, 5'd11,
    5'd21, 5'd8,  5'd9,  5'd9,  5'd1,  5'd6,  5'd17, 5'd7,
    5'd7,  5'd17, 5'd15, 5'd12, 5'd16, 5'd13, 5'd10, 5'd10,
    5'd11, 5'd14, 5'd9,  5'd5,  5'd11, 5'd22, 5'd0,  5'd8,
    5'd18, 5'd5,  5'd12, 5'd10, 5'd19, 5'd8,  5'd12, 5'd20,
    5'd8,  5'd13, 5'd19, 5'd7,  5'd5,  5'd13, 5'd18, 5'd4,
    5'd23, 5'd11, 5'd7,  5'd17, 5'd14, 5'd14, 5'd6,  5'd1,
    5'd2,  5'd18, 5'd10, 5'd15, 5'd21, 5'd19, 5'd20, 5'd15,
    5'd16, 5'd21, 5'd17, 5'd19, 5'd16, 5'd2,  5'd3,  5'd18,
    5'd6,  5'd10, 5'd16, 5'd14, 5'd17, 5'd23, 5'd17, 5'd15,
    5'd18, 5'd18, 5'd21, 5'd8,  5'd17, 5'd7,  5'd13, 5'd16,
    5'd3,  5'd4,  5'd13, 5'd16, 5'd19, 5'd19, 5'd2,  5'd5,
    5'd16, 5'd13, 5'd20, 5'd20, 5'd4,  5'd3,  5'd15, 5'd12,
    5'd9,  5'd21, 5'd18, 5'd21, 5'd15, 5'd14, 5'd23, 5'd10,
    5'd22, 5'd22, 5'd6,  5'd1,  5'd23, 5'd11, 5'd4,  5'd3,
    5'd14, 5'd23, 5'd2,  5'd9,  5'd22, 5'd23, 5'd21, 5'd0};

  // One item in flight: the coordinates still to be walked (top bit next),
  // the orientation state and the key digits gathered so far.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [ST_W-1:0]    st;
    logic [ACC_W-1:0]   key;
    logic               is_2d;
  } pipe_t;

endpackage

[src/hke_ifs.sv]
// Valid/ready channel interfaces of the Hilbert key encoder: points in, keys out, config.
// Depends on hke_pkg for the field widths.
interface hke_coord_if;
  logic                        valid;
  logic                        ready;
  logic [hke_pkg::COORD_W-1:0] coord_x;
  logic [hke_pkg::COORD_W-1:0] coord_y;
  logic [hke_pkg::COORD_W-1:0] coord_z;

  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface hke_key_if;
  logic                      valid;
  logic                      ready;
  logic [hke_pkg::KEY_W-1:0] hilbert_key;

  modport source (output valid, hilbert_key, input ready);
  modport sink (input valid, hilbert_key, output ready);
endinterface

interface hke_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [hke_pkg::MODE_W-1:0] dimension_mode;

  modport source (output valid, dimension_mode, input ready);
  modport sink (input valid, dimension_mode, output ready);
endinterface

[src/hke_walk_stage.sv]
// One slice of the Hilbert walk: STEP_2D levels of the 2D table or STEP_3D levels of the 3D table.
// Pure combinational logic; depends on hke_pkg for the tables and the pipe_t type.
module hke_walk_stage (
  input  hke_pkg::pipe_t d,
  output hke_pkg::pipe_t q
);

  logic [1:0]                st2;
  logic [3:0]                idx2;
  logic [hke_pkg::ACC_W-1:0] key2;
  logic [hke_pkg::ST_W-1:0]  st3;
  logic [7:0]                idx3;
  logic [hke_pkg::ACC_W-1:0] key3;

  always_comb begin
    st2  = d.st[1:0];
    key2 = d.key;
    idx2 = '0;
    for (int i = 0; i < hke_pkg::STEP_2D; i++) begin
      idx2 = {st2, d.x[hke_pkg::COORD_W-1-i], d.y[hke_pkg::COORD_W-1-i]};
      key2 = {key2[hke_pkg::ACC_W-3:0], hke_pkg::DIGIT2[idx2]};
      st2  = hke_pkg::NEXT2[idx2];
    end
  end

  always_comb begin
    st3  = d.st;
    key3 = d.key;
    idx3 = '0;
    for (int i = 0; i < hke_pkg::STEP_3D; i++) begin
      // An orientation outside the table restarts at the first one.
      if (st3 >= hke_pkg::ST_W'(hke_pkg::ST3_COUNT)) begin
        st3 = '0;
      end
      idx3 = {st3, d.x[hke_pkg::COORD_W-1-i], d.y[hke_pkg::COORD_W-1-i],
              d.z[hke_pkg::COORD_W-1-i]};
      key3 = {key3[hke_pkg::ACC_W-4:0], hke_pkg::DIGIT3[idx3]};
      st3  = hke_pkg::NEXT3[idx3];
    end
  end

  always_comb begin
    q = d;
    if (d.is_2d) begin
      q.st  = hke_pkg::ST_W'(st2);
      q.key = key2;
      q.x   = d.x << hke_pkg::STEP_2D;
      q.y   = d.y << hke_pkg::STEP_2D;
    end else begin
      q.st  = st3;
      q.key = key3;
      q.x   = d.x << hke_pkg::STEP_3D;
      q.y   = d.y << hke_pkg::STEP_3D;
      q.z   = d.z << hke_pkg::STEP_3D;
    end
  end

endmodule

[src/hilbert_key_encoder_unit.sv]
// Top level of the Hilbert key encoder: config register, input register, walk pipeline, output.
// Depends on hke_pkg, the interfaces in hke_ifs.sv and hke_walk_stage.
//
// Usage:
//   in_item takes one point (coord_x, coord_y, coord_z) per item; out_item returns one
//   hilbert_key per point, in order. cfg_write sets dimension_mode: 2 encodes 28 levels
//   of x/y into a 56-bit key, any other value encodes 19 levels of x/y/z into a 57-bit
//   key. Write it only while no item is in flight; cfg_write.ready is always high.
//   Throughput is one item per cycle while out_item is not stalled. An item accepted on
//   in_item passes through the input register and four walk stages, each of which
//   handles seven 2D levels or five 3D levels of the table walk, with a register after
//   each stage; the last of these is the output register, which offers it on out_item.
//   Every stage holds its item while the stage after it is full, so a stalled receiver
//   fills the pipeline from the back and in_item.ready drops only once all five
//   registers hold items. Up to five items can be in flight.
//   Reset (rst_n low at a clock edge) empties the pipeline and sets dimension_mode to 3.

module hilbert_key_encoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  hke_coord_if.sink  in_item,
  hke_key_if.source  out_item,
  hke_cfg_if.sink    cfg_write
);

  localparam int N = hke_pkg::NUM_STAGES;

  logic [hke_pkg::MODE_W-1:0] mode_r;
  logic [N:0]                 valid_r;
  hke_pkg::pipe_t             pipe_r [N+1];
  hke_pkg::pipe_t             stage_q [N];
  hke_pkg::pipe_t             entry;
  logic [N:0]                 stage_rdy;
  logic [hke_pkg::EXT_W-1:0]  key_ext;
  logic [hke_pkg::EXT_W-1:0]  key_shifted;

  assign cfg_write.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= hke_pkg::MODE_RESET;
    end else if (cfg_write.valid) begin
      mode_r <= cfg_write.dimension_mode;
    end
  end

  // A stage can load when it is empty or its item moves on in the same cycle.
  always_comb begin
    stage_rdy[N] = !valid_r[N] || out_item.ready;
    for (int k = N - 1; k >= 0; k--) begin
      stage_rdy[k] = !valid_r[k] || stage_rdy[k+1];
    end
  end

  assign in_item.ready = stage_rdy[0];

  always_comb begin
    entry.x     = in_item.coord_x;
    entry.y     = in_item.coord_y;
    entry.z     = in_item.coord_z;
    entry.st    = '0;
    entry.key   = '0;
    entry.is_2d = (mode_r == hke_pkg::MODE_2D);
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    hke_walk_stage u_stage (
      .d (pipe_r[g]),
      .q (stage_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (stage_rdy[0]) begin
        valid_r[0] <= in_item.valid;
      end
      for (int k = 1; k <= N; k++) begin
        if (stage_rdy[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_rdy[0]) begin
      pipe_r[0] <= entry;
    end
    for (int k = 1; k <= N; k++) begin
      if (stage_rdy[k]) begin
        pipe_r[k] <= stage_q[k-1];
      end
    end
  end

  // The last stage may have walked padding levels; drop their digits.
  always_comb begin
    key_ext = hke_pkg::EXT_W'(pipe_r[N].key);
    if (pipe_r[N].is_2d) begin
      key_shifted = key_ext >> (2 * hke_pkg::PAD_2D);
    end else begin
      key_shifted = key_ext >> (3 * hke_pkg::PAD_3D);
    end
  end

  assign out_item.valid       = valid_r[N];
  assign out_item.hilbert_key = key_shifted[hke_pkg::KEY_W-1:0];

  // Reset empties every pipeline register.
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> valid_r == '0)
    else $error("pipeline not empty after reset");

  // A finished 3D item never carries an orientation outside the table.
  a_state_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[N] && !pipe_r[N].is_2d |-> pipe_r[N].st < hke_pkg::ST_W'(hke_pkg::ST3_COUNT))
    else $error("3D orientation state out of range");

  // A result that the receiver has not taken stays in the output register.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[N] && !out_item.ready |=> valid_r[N] && $stable(pipe_r[N].key))
    else $error("stalled result lost or changed");

  // A 2D key never reaches the top key bit.
  a_2d_width: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[N] && pipe_r[N].is_2d |-> !out_item.hilbert_key[hke_pkg::KEY_W-1])
    else $error("2D key wider than its level count allows");

endmodule

[test/tb_hilbert_key_encoder_unit.sv]
// Self-checking testbench for hilbert_key_encoder_unit: directed and random points in both modes,
// with a Hilbert key predictor, random idling on both channels and a long receiver hold-off.
// Depends on hke_pkg, the channel interfaces in hke_ifs.sv and the encoder top level.
`timescale 1ns / 100ps

module tb_hilbert_key_encoder_unit;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 20;

  // Mode values other than the 2D one all select the 3D walk.
  localparam logic [hke_pkg::MODE_W-1:0] MODE_3D_ZERO = 2'd0;
  localparam logic [hke_pkg::MODE_W-1:0] MODE_3D_ONE  = 2'd1;
  localparam logic [hke_pkg::MODE_W-1:0] MODE_3D      = 2'd3;

  typedef struct {
    logic [hke_pkg::COORD_W-1:0] x;
    logic [hke_pkg::COORD_W-1:0] y;
    logic [hke_pkg::COORD_W-1:0] z;
  } point_t;

  typedef struct {
    point_t                      pt;
    logic [hke_pkg::MODE_W-1:0]  mode;
    logic [hke_pkg::KEY_W-1:0]   key;
  } expected_key_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hke_coord_if coord_if ();
  hke_key_if   key_if ();
  hke_cfg_if   cfg_if ();

  hilbert_key_encoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (coord_if),
    .out_item  (key_if),
    .cfg_write (cfg_if)
  );

  point_t                     points_to_send [$];
  expected_key_t              expected_keys [$];
  logic [hke_pkg::MODE_W-1:0] encode_mode = hke_pkg::MODE_RESET;
  int                         sender_idle_pct = 0;
  int                         receiver_stall_pct = 0;
  int                         hold_requests = 0;
  int                         hold_granted = 0;
  int                         hold_left = 0;
  int                         error_count = 0;
  int                         cycle_count = 0;

  always #5 clk = ~clk;

  // Walks the orientation tables one level at a time, top coordinate bit first.
  function automatic logic [hke_pkg::KEY_W-1:0] hilbert_key_of(
      input logic [hke_pkg::MODE_W-1:0] mode, input point_t pt);
    logic [hke_pkg::KEY_W-1:0] key;
    logic [4:0]                orient;
    logic [3:0]                idx2;
    logic [7:0]                idx3;
    key = '0;
    orient = '0;
    if (mode == hke_pkg::MODE_2D) begin
      for (int lvl = 0; lvl < hke_pkg::LEVELS_2D; lvl++) begin
        idx2 = {orient[1:0], pt.x[hke_pkg::COORD_W-1-lvl], pt.y[hke_pkg::COORD_W-1-lvl]};
        key = {key[hke_pkg::KEY_W-3:0], hke_pkg::DIGIT2[idx2]};
        orient = {3'd0, hke_pkg::NEXT2[idx2]};
      end
    end else begin
      for (int lvl = 0; lvl < hke_pkg::LEVELS_3D; lvl++) begin
        idx3 = {orient, pt.x[hke_pkg::COORD_W-1-lvl], pt.y[hke_pkg::COORD_W-1-lvl],
                pt.z[hke_pkg::COORD_W-1-lvl]};
        key = {key[hke_pkg::KEY_W-4:0], hke_pkg::DIGIT3[idx3]};
        orient = hke_pkg::NEXT3[idx3];
      end
    end
    return key;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic push_point(input logic [hke_pkg::COORD_W-1:0] x,
                            input logic [hke_pkg::COORD_W-1:0] y,
                            input logic [hke_pkg::COORD_W-1:0] z);
    point_t pt;
    pt.x = x;
    pt.y = y;
    pt.z = z;
    points_to_send.push_back(pt);
  endtask

  // Mostly uniform values, with a share of all-zero, all-one, single-bit and single-zero-bit patterns.
  function automatic logic [hke_pkg::COORD_W-1:0] random_coord();
    logic [hke_pkg::COORD_W-1:0] one_bit;
    one_bit = 32'h1 << $urandom_range(31);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return one_bit;
      3: return ~one_bit;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++)
      push_point(random_coord(), random_coord(), random_coord());
  endtask

  task automatic wait_all_keys();
    while (points_to_send.size() != 0 || expected_keys.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_mode(input logic [hke_pkg::MODE_W-1:0] mode);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.dimension_mode <= mode;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    encode_mode = mode;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // Sender: holds an offered item until it is taken, then offers the next one or idles.
  always @(posedge clk) begin
    expected_key_t exp_item;
    if (!rst_n) begin
      coord_if.valid <= 1'b0;
    end else begin
      if (coord_if.valid && coord_if.ready) begin
        exp_item.pt = points_to_send.pop_front();
        exp_item.mode = encode_mode;
        exp_item.key = hilbert_key_of(encode_mode, exp_item.pt);
        expected_keys.push_back(exp_item);
      end
      if (!(coord_if.valid && !coord_if.ready)) begin
        if (points_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          coord_if.valid <= 1'b1;
          coord_if.coord_x <= points_to_send[0].x;
          coord_if.coord_y <= points_to_send[0].y;
          coord_if.coord_z <= points_to_send[0].z;
        end else begin
          coord_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started on request, so that the pipeline fills up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_granted != hold_requests) begin
      hold_left <= HOLD_CYCLES;
      hold_granted <= hold_granted + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      key_if.ready <= 1'b0;
    else
      key_if.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    expected_key_t exp_item;
    if (rst_n && key_if.valid && key_if.ready) begin
      if (expected_keys.size() == 0) begin
        report_error($sformatf("unexpected key %h", key_if.hilbert_key));
      end else begin
        exp_item = expected_keys.pop_front();
        if (key_if.hilbert_key !== exp_item.key)
          report_error($sformatf("mode %0d point %h %h %h: key %h, expected %h",
                                 exp_item.mode, exp_item.pt.x, exp_item.pt.y, exp_item.pt.z,
                                 key_if.hilbert_key, exp_item.key));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    coord_if.valid = 1'b0;
    coord_if.coord_x = '0;
    coord_if.coord_y = '0;
    coord_if.coord_z = '0;
    key_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.dimension_mode = hke_pkg::MODE_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // 3D corners with the mode left at its reset value.
    set_idling(0, 0);
    push_point('0, '0, '0);
    push_point('1, '1, '1);
    push_point('1, '0, '0);
    push_point('0, '1, '0);
    push_point('0, '0, '1);
    push_point(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
    push_point(32'h80000000, 32'h40000000, 32'h20000000);
    // Only bits below the last 3D level are set, so the key is zero.
    push_point(32'h00001FFF, 32'h00001FFF, 32'h00001FFF);
    push_point(32'hFFFFE000, 32'h0, 32'hFFFFE000);
    wait_all_keys();

    // 2D corners; the same x and y with different z must give the same key.
    write_mode(hke_pkg::MODE_2D);
    push_point('0, '0, '1);
    push_point('1, '1, '0);
    push_point('1, '0, '0);
    push_point('0, '1, '0);
    push_point(32'h12345678, 32'h9ABCDEF0, '0);
    push_point(32'h12345678, 32'h9ABCDEF0, '1);
    push_point(32'h0000000F, 32'h0000000F, '1);
    push_point(32'hAAAAAAAA, 32'h55555555, '0);
    push_point(32'h80000000, '0, 32'h80000000);
    wait_all_keys();

    set_idling(73, 0);
    push_random(100);
    wait_all_keys();

    write_mode(MODE_3D_ZERO);
    set_idling(0, 73);
    push_random(100);
    wait_all_keys();

    write_mode(MODE_3D_ONE);
    set_idling(25, 25);
    push_random(100);
    wait_all_keys();

    write_mode(MODE_3D);
    set_idling(0, 0);
    push_random(100);
    wait_all_keys();

    // Receiver holds off while the sender keeps offering, so the input stalls.
    write_mode(hke_pkg::MODE_2D);
    set_idling(0, 0);
    hold_requests++;
    push_random(60);
    wait_all_keys();

    write_mode(MODE_3D);
    set_idling(25, 25);
    hold_requests++;
    push_random(100);
    wait_all_keys();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
src/hke_pkg.sv
src/hke_ifs.sv
src/hke_walk_stage.sv
src/hilbert_key_encoder_unit.sv
test/tb_hilbert_key_encoder_unit.sv
